// ----- rtl/core/great_circle_distance_time_defines.svh -----
// Assertion macros used by the checker file.
`ifndef GREAT_CIRCLE_DISTANCE_TIME_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_TIME_DEFINES_SVH

// Implication checked outside reset.
`define GCDT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("gcdt assertion failed");

// Next-cycle implication, also checked across reset.
`define GCDT_ASSERT_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("gcdt assertion failed");

`endif

// ----- rtl/core/gcdt_pkg.sv -----
package gcdt_pkg;

   localparam int CW         = 34;   // CORDIC datapath width
   localparam int SQW        = 62;   // square-root datapath width
   localparam int STEPS      = 30;   // CORDIC iterations
   localparam int SQRT_STEPS = 31;   // one result bit per step
   localparam int PREP_LAT   = 8;    // angle reduction stages
   localparam int LATENCY    = 1 + PREP_LAT + STEPS + 1 + 3 + SQRT_STEPS + STEPS + 3;

   localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;
   localparam logic        [63:0] PI_Q30   = 64'd3373259426;
   localparam logic signed [63:0] HALF_PI  = 64'sd1686629713;
   localparam logic signed [63:0] GAIN_INV = 64'sd652032874;

   localparam logic [23:0] RADIUS_RESET = 24'd1013453;
   localparam logic [63:0] DIST_MAX     = 64'd67108863;
   localparam logic [63:0] HOURS_MAX    = 64'd131071;
   localparam logic [63:0] FLIGHT_DIV   = 64'd125;
   localparam logic [63:0] RECIP125     = (64'd1 << 32) / FLIGHT_DIV;
   localparam logic [63:0] HOURS_BIAS   = 64'd250 << 30;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_vec_type;

   typedef struct packed {
      logic [SQW-1:0] n;
      logic [SQW-1:0] res;
   } sqrt_vec_type;

   function automatic logic signed [CW-1:0] atan_q30(input int k);
      case (k)
         0:  return 34'h3243F6A8;
         1:  return 34'h1DAC6705;
         2:  return 34'h0FADBAFC;
         3:  return 34'h07F56EA6;
         4:  return 34'h03FEAB76;
         5:  return 34'h01FFD55B;
         6:  return 34'h00FFFAAA;
         7:  return 34'h007FFF55;
         8:  return 34'h003FFFEA;
         9:  return 34'h001FFFFD;
         10: return 34'h000FFFFF;
         11: return 34'h0007FFFF;
         12: return 34'h0003FFFF;
         13: return 34'h0001FFFF;
         14: return 34'h0000FFFF;
         15: return 34'h00007FFF;
         16: return 34'h00003FFF;
         17: return 34'h00001FFF;
         18: return 34'h00000FFF;
         19: return 34'h000007FF;
         20: return 34'h000003FF;
         21: return 34'h000001FF;
         22: return 34'h000000FF;
         23: return 34'h0000007F;
         24: return 34'h0000003F;
         25: return 34'h0000001F;
         26: return 34'h0000000F;
         27: return 34'h00000008;
         28: return 34'h00000004;
         29: return 34'h00000002;
         default: return '0;
      endcase
   endfunction

endpackage

// ----- rtl/core/great_circle_distance_time.sv -----
// Haversine great-circle distance and flight time, fully pipelined.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// The rate is set by the chains of CORDIC and square-root cells, one step a stage.
// Reset (synchronous, active high) drops all items in flight and restores the radius.
module great_circle_distance_time #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_start_lat,
   input  logic signed [24:0] req_start_lon,
   input  logic signed [23:0] req_end_lat,
   input  logic signed [24:0] req_end_lon,
   output logic               rsp_strobe,
   output logic [25:0]        rsp_distance,
   output logic [16:0]        rsp_flight_hours,
   input  logic               csr_we,
   input  logic [23:0]        csr_wdata
);

   localparam int CW    = gcdt_pkg::CW;
   localparam int STEPS = gcdt_pkg::STEPS;
   localparam int SQS   = gcdt_pkg::SQRT_STEPS;
   localparam int LAT   = gcdt_pkg::LATENCY;

   // Item tracking: one valid bit per pipeline stage.
   logic [LAT-1:0]      vld_in, vld_ff;
   logic [23:0]         radius_ff;

   // Chains: start latitude, end latitude, latitude delta, longitude delta.
   logic signed [25:0]  ang_ff [0:3];
   logic signed [CW-1:0] prep_z [0:3];
   logic                prep_flip [0:3];
   logic [STEPS-1:0]    flip_ff [0:3];
   gcdt_pkg::cordic_vec_type rot_v [0:3][0:STEPS];
   logic signed [CW-1:0] xc [0:3];
   logic signed [31:0]  cos_ff [0:3];

   logic [30:0]         havlat_in, havlon_in, havlat1_ff, havlon1_ff, havlat2_ff;
   logic signed [63:0]  prod1_ff, prod2_in, prod2_ff, asum;
   logic signed [31:0]  p_q30;
   logic [30:0]         a_in, a_ff, one_minus_a;

   gcdt_pkg::sqrt_vec_type sq_y [0:SQS];
   gcdt_pkg::sqrt_vec_type sq_x [0:SQS];
   gcdt_pkg::cordic_vec_type vec_v [0:STEPS];

   logic signed [CW-1:0] zt;
   logic [30:0]         theta;
   logic [55:0]         prod_in, prod_ff;
   logic [56:0]         dist_raw;
   logic [25:0]         dist_in, dist_ff;
   logic [24:0]         hx_in, hx_ff, hrem;
   logic [50:0]         hm_in, hm_ff;
   logic [18:0]         hq, hours_raw;
   logic [16:0]         hours_in;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[LAT-2:0], start};

   // Hold the radius; write it only from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         radius_ff <= gcdt_pkg::RADIUS_RESET;
      end else begin
         vld_ff <= vld_in;
         if (csr_we) begin
            radius_ff <= csr_wdata;
         end
      end
   end

   // Capture the item and form the coordinate deltas.
   always_ff @(posedge clock) begin
      ang_ff[0] <= 26'(req_start_lat);
      ang_ff[1] <= 26'(req_end_lat);
      ang_ff[2] <= 26'(req_end_lat) - 26'(req_start_lat);
      ang_ff[3] <= 26'(req_end_lon) - 26'(req_start_lon);
   end

   // Four cosine chains: angle reduction, then a row of rotation cells.
   for (genvar j = 0; j < 4; j++) begin : g_cos
      gcdt_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep (
         .clock     (clock),
         .src_angle (ang_ff[j]),
         .dst_z     (prep_z[j]),
         .dst_flip  (prep_flip[j])
      );

      assign rot_v[j][0] = '{x: CW'(gcdt_pkg::GAIN_INV), y: '0, z: prep_z[j]};

      for (genvar k = 0; k < STEPS; k++) begin : g_cell
         gcdt_cordic_cell #(.SHIFT(k), .VECTOR(1'b0)) u_cell (
            .clock (clock),
            .src   (rot_v[j][k]),
            .dst   (rot_v[j][k+1])
         );
      end

      // Carry the quadrant flip alongside the cells.
      always_ff @(posedge clock) begin
         flip_ff[j] <= {flip_ff[j][STEPS-2:0], prep_flip[j]};
      end

      // Clamp to [-1, 1] and restore the sign.
      always_comb begin
         if (rot_v[j][STEPS].x > CW'(gcdt_pkg::ONE_Q30)) begin
            xc[j] = CW'(gcdt_pkg::ONE_Q30);
         end else if (rot_v[j][STEPS].x < -CW'(gcdt_pkg::ONE_Q30)) begin
            xc[j] = -CW'(gcdt_pkg::ONE_Q30);
         end else begin
            xc[j] = rot_v[j][STEPS].x;
         end
      end

      always_ff @(posedge clock) begin
         cos_ff[j] <= flip_ff[j][STEPS-1] ? 32'(-xc[j]) : 32'(xc[j]);
      end
   end

   // Haversine term a = hav(dlat) + cos(lat1) cos(lat2) hav(dlon).
   always_comb begin
      havlat_in = 31'((gcdt_pkg::ONE_Q30 - 64'(cos_ff[2])) >>> 1);
      havlon_in = 31'((gcdt_pkg::ONE_Q30 - 64'(cos_ff[3])) >>> 1);
      p_q30     = 32'(prod1_ff >>> 30);
      prod2_in  = p_q30 * $signed({1'b0, havlon1_ff});
      asum      = $signed({33'b0, havlat2_ff}) + (prod2_ff >>> 30);
      if (asum < 0) begin
         a_in = '0;
      end else if (asum > gcdt_pkg::ONE_Q30) begin
         a_in = 31'(gcdt_pkg::ONE_Q30);
      end else begin
         a_in = 31'(asum);
      end
      one_minus_a = 31'(gcdt_pkg::ONE_Q30) - a_ff;
   end

   always_ff @(posedge clock) begin
      prod1_ff   <= cos_ff[0] * cos_ff[1];
      havlat1_ff <= havlat_in;
      havlon1_ff <= havlon_in;
      prod2_ff   <= prod2_in;
      havlat2_ff <= havlat1_ff;
      a_ff       <= a_in;
   end

   // Two square-root rows: sqrt(a) and sqrt(1 - a), in Q30.
   assign sq_y[0] = '{n: gcdt_pkg::SQW'({a_ff, 30'b0}), res: '0};
   assign sq_x[0] = '{n: gcdt_pkg::SQW'({one_minus_a, 30'b0}), res: '0};

   for (genvar i = 0; i < SQS; i++) begin : g_sqrt
      gcdt_sqrt_cell #(.STEP(i)) u_sy (
         .clock (clock),
         .src   (sq_y[i]),
         .dst   (sq_y[i+1])
      );
      gcdt_sqrt_cell #(.STEP(i)) u_sx (
         .clock (clock),
         .src   (sq_x[i]),
         .dst   (sq_x[i+1])
      );
   end

   // Vectoring row: atan2(sqrt(a), sqrt(1 - a)) accumulates in z.
   assign vec_v[0] = '{x: CW'(sq_x[SQS].res), y: CW'(sq_y[SQS].res), z: '0};

   for (genvar k = 0; k < STEPS; k++) begin : g_vec
      gcdt_cordic_cell #(.SHIFT(k), .VECTOR(1'b1)) u_cell (
         .clock (clock),
         .src   (vec_v[k]),
         .dst   (vec_v[k+1])
      );
   end

   // Clamp the angle to [0, pi/2], scale by the radius, then round and saturate.
   always_comb begin
      zt = vec_v[STEPS].z;
      if (zt < 0) begin
         theta = '0;
      end else if (zt > CW'(gcdt_pkg::HALF_PI)) begin
         theta = 31'(gcdt_pkg::HALF_PI);
      end else begin
         theta = 31'(zt);
      end
      prod_in  = 56'(radius_ff) * 56'({theta, 1'b0});
      dist_raw = (57'(prod_ff) + (57'(1) << 29)) >> 30;
      dist_in  = (64'(dist_raw) > gcdt_pkg::DIST_MAX) ? 26'(gcdt_pkg::DIST_MAX)
                                                      : 26'(dist_raw);
      hx_in    = 25'((57'(prod_ff) + 57'(gcdt_pkg::HOURS_BIAS)) >> 32);
      hm_in    = hx_in * gcdt_pkg::RECIP125[25:0];
      // Reciprocal estimate may sit one low: correct with one compare.
      hq        = 19'(hm_ff >> 32);
      hrem      = hx_ff - 25'(64'(hq) * gcdt_pkg::FLIGHT_DIV);
      hours_raw = (64'(hrem) >= gcdt_pkg::FLIGHT_DIV) ? hq + 19'd1 : hq;
      hours_in  = (64'(hours_raw) > gcdt_pkg::HOURS_MAX) ? 17'(gcdt_pkg::HOURS_MAX)
                                                         : 17'(hours_raw);
   end

   always_ff @(posedge clock) begin
      prod_ff          <= prod_in;
      dist_ff          <= dist_in;
      hx_ff            <= hx_in;
      hm_ff            <= hm_in;
      rsp_distance     <= dist_ff;
      rsp_flight_hours <= hours_in;
   end

   assign rsp_strobe = vld_ff[LAT-1];

endmodule

// ----- rtl/core/gcdt_cordic_cell.sv -----
module gcdt_cordic_cell #(
   parameter int SHIFT  = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic                    clock,
   input  gcdt_pkg::cordic_vec_type src,
   output gcdt_pkg::cordic_vec_type dst
);

   logic signed [gcdt_pkg::CW-1:0] sx, sy, ang;
   logic                           go_pos, dir;
   gcdt_pkg::cordic_vec_type       vec_in, vec_ff;

   // Rotation steers on z, vectoring on y.
   always_comb begin
      sx     = src.x >>> SHIFT;
      sy     = src.y >>> SHIFT;
      ang    = gcdt_pkg::atan_q30(SHIFT);
      go_pos = VECTOR ? ~src.y[gcdt_pkg::CW-1] : ~src.z[gcdt_pkg::CW-1];
      dir    = go_pos ^ VECTOR;
      if (dir) begin
         vec_in.x = src.x - sy;
         vec_in.y = src.y + sx;
         vec_in.z = src.z - ang;
      end else begin
         vec_in.x = src.x + sy;
         vec_in.y = src.y - sx;
         vec_in.z = src.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign dst = vec_ff;

endmodule

// ----- rtl/core/gcdt_sqrt_cell.sv -----
module gcdt_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  gcdt_pkg::sqrt_vec_type src,
   output gcdt_pkg::sqrt_vec_type dst
);

   localparam logic [gcdt_pkg::SQW-1:0] BIT = gcdt_pkg::SQW'(1) << (60 - 2 * STEP);

   logic [gcdt_pkg::SQW-1:0] trial;
   gcdt_pkg::sqrt_vec_type   vec_in, vec_ff;

   // Settle one result bit: subtract the trial square when it fits.
   always_comb begin
      trial = src.res + BIT;
      if (src.n >= trial) begin
         vec_in.n   = src.n - trial;
         vec_in.res = (src.res >> 1) + BIT;
      end else begin
         vec_in.n   = src.n;
         vec_in.res = src.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign dst = vec_ff;

endmodule

// ----- rtl/core/gcdt_angle_prep.sv -----
module gcdt_angle_prep #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic signed [25:0]             src_angle,
   output logic signed [gcdt_pkg::CW-1:0] dst_z,
   output logic                           dst_flip
);

   localparam int F = ANGLE_FRAC_BITS;
   localparam logic [63:0] TURN    = 64'd360 << F;
   localparam logic [63:0] HALF    = 64'd180 << F;
   localparam logic [63:0] QUARTER = 64'd90 << F;
   localparam logic [63:0] BIAS    = ((64'd1 << 25) + TURN - 64'd1) / TURN * TURN;
   localparam int NW      = ((F + 9 > 26) ? F + 9 : 26) + 2;
   localparam int SH_T    = NW + 1;
   localparam logic [63:0] RECIP_T = (64'd1 << SH_T) / TURN;
   localparam int RW_T    = $clog2(RECIP_T + 64'd1);
   localparam int AW      = F + 10;
   localparam int MW      = F + 7;
   localparam int PW      = MW + 32;
   localparam int XW      = 37;
   localparam int SH45    = 38;
   localparam logic [63:0] DIV45   = 64'd45;
   localparam logic [63:0] RECIP45 = (64'd1 << SH45) / DIV45;

   logic [NW-1:0]          n_in, n_ff, n2_ff, q_t, rr_in, rr_ff, rc;
   logic [NW+RW_T-1:0]     pw_in, pw_ff;
   logic signed [AW-1:0]   r_in, r_ff;
   logic [AW-1:0]          mag;
   logic [MW-1:0]          m_in, m_ff;
   logic                   flip_in, flip5_ff, flip6_ff, flip7_ff, flip8_ff;
   logic [PW-1:0]          p_in, p_ff;
   logic [XW-1:0]          x_in, x_ff, rem;
   logic [XW+32:0]         xr_in, xr_ff;
   logic [31:0]            q45, z_in, z_ff;

   always_comb begin
      // Offset so that the remainder by a full turn lands on [-180, 180).
      n_in  = NW'(64'($signed(src_angle)) + HALF + BIAS);
      pw_in = n_ff * RECIP_T[RW_T-1:0];
      q_t   = NW'(pw_ff >> SH_T);
      rr_in = n2_ff - NW'(64'(q_t) * TURN);
      rc    = (64'(rr_ff) >= TURN) ? NW'(64'(rr_ff) - TURN) : rr_ff;
      r_in  = AW'(64'(rc) - HALF);
      // Fold into the first quadrant and remember the sign flip.
      mag     = r_ff[AW-1] ? AW'(-r_ff) : AW'(r_ff);
      flip_in = 64'(mag) > QUARTER;
      m_in    = MW'(flip_in ? HALF - 64'(mag) : 64'(mag));
      p_in    = PW'(64'(m_ff) * gcdt_pkg::PI_Q30 + QUARTER);
      x_in    = XW'(p_ff >> (F + 2));
      xr_in   = x_in * RECIP45[32:0];
      q45     = 32'(xr_ff >> SH45);
      rem     = x_ff - XW'(64'(q45) * DIV45);
      z_in    = (64'(rem) >= DIV45) ? q45 + 32'd1 : q45;
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      pw_ff    <= pw_in;
      n2_ff    <= n_ff;
      rr_ff    <= rr_in;
      r_ff     <= r_in;
      m_ff     <= m_in;
      flip5_ff <= flip_in;
      p_ff     <= p_in;
      flip6_ff <= flip5_ff;
      xr_ff    <= xr_in;
      x_ff     <= x_in;
      flip7_ff <= flip6_ff;
      z_ff     <= z_in;
      flip8_ff <= flip7_ff;
   end

   assign dst_z    = {{(gcdt_pkg::CW-32){1'b0}}, z_ff};
   assign dst_flip = flip8_ff;

endmodule

// ----- rtl/core/gcdt_checker.sv -----
`include "great_circle_distance_time_defines.svh"

module gcdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [25:0] rsp_distance,
   input logic [16:0] rsp_flight_hours
);

   localparam int LAT = gcdt_pkg::LATENCY;

   // Every accepted item yields its result after the fixed latency.
   `GCDT_ASSERT_IMP(a_item_result, clock, reset, start && !busy, ##LAT rsp_strobe)
   // No result without an item accepted the fixed latency earlier.
   `GCDT_ASSERT_IMP(a_result_source, clock, reset, rsp_strobe, $past(start, LAT))
   // Hours are the distance divided by the speed, never larger.
   `GCDT_ASSERT_IMP(a_hours_bound, clock, reset, rsp_strobe,
                    ({9'b0, rsp_flight_hours} <= rsp_distance))
   // Reset drops every item in flight.
   `GCDT_ASSERT_NXT(a_reset_flush, clock, reset, !rsp_strobe)

endmodule

bind great_circle_distance_time gcdt_checker u_gcdt_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_distance     (rsp_distance),
   .rsp_flight_hours (rsp_flight_hours)
);

// ----- bench/tb_great_circle_distance_time.sv -----
module tb_great_circle_distance_time;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM   = 1550;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = gcdt_pkg::LATENCY + 20;
   localparam longint LAT_MAX = 64'sd5898240;
   localparam longint LON_MAX = 64'sd11796480;

   // One coordinate pair plus the result it should give.
   typedef struct {
      logic signed [23:0] slat;
      logic signed [24:0] slon;
      logic signed [23:0] elat;
      logic signed [24:0] elon;
      logic               typed;
      logic [25:0]        miles;
      logic [16:0]        hours;
   } route_row_type;

   typedef struct {
      logic [25:0] miles;
      logic [16:0] hours;
   } leg_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [23:0] req_start_lat = '0;
   logic signed [24:0] req_start_lon = '0;
   logic signed [23:0] req_end_lat = '0;
   logic signed [24:0] req_end_lon = '0;
   logic               rsp_strobe;
   logic [25:0]        rsp_distance;
   logic [16:0]        rsp_flight_hours;
   logic               csr_we = 1'b0;
   logic [23:0]        csr_wdata = '0;

   logic [23:0] radius_model;
   leg_type     leg_queue[$];
   int          fail_count = 0;
   int          idle_cycles = 0;

   always #1 clock = ~clock;

   great_circle_distance_time u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_lat(req_start_lat), .req_start_lon(req_start_lon),
      .req_end_lat(req_end_lat), .req_end_lon(req_end_lon),
      .rsp_strobe(rsp_strobe), .rsp_distance(rsp_distance),
      .rsp_flight_hours(rsp_flight_hours),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------- predictor
   localparam longint ATAN_TAB[30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

   // Cosine in Q30 of an angle in degrees with 16 fraction bits.
   function automatic longint cos_q30(input longint deg);
      longint turn, r, z, xv, yv, dx, dy;
      longint unsigned mag, half, quarter;
      bit flip;
      turn = longint'(360) <<< 16;
      r = deg % turn;
      if (r < 0) r += turn;
      if (r >= turn / 2) r -= turn;
      mag = (r < 0) ? -r : r;
      half = 64'd180 << 16;
      quarter = 64'd90 << 16;
      flip = 0;
      if (mag > quarter) begin
         mag = half - mag;
         flip = 1;
      end
      z = (mag * gcdt_pkg::PI_Q30 + half / 2) / half;
      xv = gcdt_pkg::GAIN_INV;
      yv = 0;
      for (int k = 0; k < 30; k++) begin
         dx = yv >>> k;
         dy = xv >>> k;
         if (z >= 0) begin
            xv -= dx; yv += dy; z -= ATAN_TAB[k];
         end else begin
            xv += dx; yv -= dy; z += ATAN_TAB[k];
         end
      end
      if (xv > gcdt_pkg::ONE_Q30) xv = gcdt_pkg::ONE_Q30;
      if (xv < -gcdt_pkg::ONE_Q30) xv = -gcdt_pkg::ONE_Q30;
      return flip ? -xv : xv;
   endfunction

   function automatic longint unsigned isqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Half the central angle in Q30, atan2 by vectoring, clamped to [0, pi/2].
   function automatic longint central_half_angle(input longint yv, input longint xv);
      longint z, sy, sx;
      z = 0;
      for (int k = 0; k < 30; k++) begin
         sy = yv >>> k;
         sx = xv >>> k;
         if (yv >= 0) begin
            xv += sy; yv -= sx; z += ATAN_TAB[k];
         end else begin
            xv -= sy; yv += sx; z -= ATAN_TAB[k];
         end
      end
      if (z < 0) z = 0;
      if (z > longint'(gcdt_pkg::PI_Q30) / 2) z = longint'(gcdt_pkg::PI_Q30) / 2;
      return z;
   endfunction

   function automatic leg_type predict_leg(input route_row_type r);
      longint slat, slon, elat, elon, c1, c2, hlat, hlon, p, a, ys, xs, th;
      longint unsigned prod, d, h;
      leg_type res;
      slat = r.slat; slon = r.slon; elat = r.elat; elon = r.elon;
      c1 = cos_q30(slat);
      c2 = cos_q30(elat);
      hlat = (gcdt_pkg::ONE_Q30 - cos_q30(elat - slat)) >>> 1;
      hlon = (gcdt_pkg::ONE_Q30 - cos_q30(elon - slon)) >>> 1;
      p = (c1 * c2) >>> 30;
      a = hlat + ((p * hlon) >>> 30);
      if (a < 0) a = 0;
      if (a > gcdt_pkg::ONE_Q30) a = gcdt_pkg::ONE_Q30;
      ys = isqrt(longint'(a) << 30);
      xs = isqrt(longint'(gcdt_pkg::ONE_Q30 - a) << 30);
      th = central_half_angle(ys, xs);
      prod = longint'(radius_model) * (th * 2);
      d = (prod + (64'd1 << 29)) >> 30;
      h = (prod + (64'd500 << 29)) / (64'd500 << 30);
      if (d > gcdt_pkg::DIST_MAX) d = gcdt_pkg::DIST_MAX;
      if (h > gcdt_pkg::HOURS_MAX) h = gcdt_pkg::HOURS_MAX;
      res.miles = d[25:0];
      res.hours = h[16:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      leg_type want;
      if (!reset && rsp_strobe) begin
         if (leg_queue.size() == 0) begin
            $error("result with no item pending: distance %0d", rsp_distance);
            fail_count++;
         end else begin
            want = leg_queue.pop_front();
            if (rsp_distance !== want.miles) begin
               $error("distance expected %0d actual %0d", want.miles, rsp_distance);
               fail_count++;
            end
            if (rsp_flight_hours !== want.hours) begin
               $error("flight_hours expected %0d actual %0d", want.hours,
                      rsp_flight_hours);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles in which no item moves either way.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[great_circle_distance_time] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   int burst_left = 0;

   // Present one item, hold it until accepted, and queue what it should give.
   task automatic send_route(input route_row_type r);
      leg_type want;
      // Between bursts, usually insert a gap with start low.
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_start_lat <= r.slat;
      req_start_lon <= r.slon;
      req_end_lat <= r.elat;
      req_end_lon <= r.elon;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = predict_leg(r);
      if (r.typed) begin
         // Hand-entered values must agree with the predictor too.
         if (want.miles !== r.miles) begin
            $error("table row distance expected %0d actual %0d", r.miles, want.miles);
            fail_count++;
         end
         if (want.hours !== r.hours) begin
            $error("table row flight_hours expected %0d actual %0d", r.hours,
                   want.hours);
            fail_count++;
         end
      end
      leg_queue = {leg_queue, want};
   endtask

   // Drain the pipe, then write the radius while the block is idle.
   task automatic set_radius(input logic [23:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (leg_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      radius_model = value;
   endtask

   function automatic route_row_type row(input longint a, input longint b,
                                         input longint c, input longint d);
      route_row_type r;
      r.slat = 24'(a); r.slon = 25'(b); r.elat = 24'(c); r.elon = 25'(d);
      r.typed = 0; r.miles = '0; r.hours = '0;
      return r;
   endfunction

   function automatic route_row_type row_typed(input longint a, input longint b,
                                               input longint c, input longint d,
                                               input logic [25:0] miles,
                                               input logic [16:0] hours);
      route_row_type r;
      r = row(a, b, c, d);
      r.typed = 1; r.miles = miles; r.hours = hours;
      return r;
   endfunction

   // Pick a coordinate: mostly in range, sometimes any bit pattern.
   function automatic longint rand_coord(input int width, input longint lim);
      longint v;
      case ($urandom_range(0, 9))
         0: v = $signed(($urandom() & ((1 << width) - 1)) << (32 - width)) >>> (32 - width);
         1: v = $urandom_range(0, 1) ? lim : -lim;
         default: v = longint'($urandom_range(0, 2 * lim)) - lim;
      endcase
      return v;
   endfunction

   route_row_type route_table[$];

   function automatic void add_route(input route_row_type r);
      route_table = {route_table, r};
   endfunction

   initial begin
      route_row_type r;
      radius_model = gcdt_pkg::RADIUS_RESET;

      // Identical points.
      add_route(row(0, 0, 0, 0));
      add_route(row(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
      add_route(row(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX));
      // Antipodal points: half a circumference.
      add_route(row(0, 0, 0, LON_MAX));
      add_route(row(LAT_MAX, 0, -LAT_MAX, 0));
      add_route(row(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
      add_route(row(2949120, 0, -2949120, LON_MAX));
      // Quarter circles and small steps.
      add_route(row(0, 0, LAT_MAX, 0));
      add_route(row(0, 0, 0, 5898240));
      add_route(row(0, 0, 1, 0));
      add_route(row(0, 0, 0, 1));
      add_route(row(-1, -1, 1, 1));
      // Out-of-range patterns: wrap and latitude beyond the pole.
      add_route(row(24'h7FFFFF, 25'h0FFFFFF, -24'sd8388608, -25'sd16777216));
      add_route(row(-24'sd8388608, 0, 24'h7FFFFF, 0));
      add_route(row(7864320, 0, 0, 0));
      add_route(row(0, 16777215, 0, -16777216));
      add_route(row(-1, -1, -1, -1));
      add_route(row(2672099, -4859453, 3342995, 151863));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (route_table[i]) send_route(route_table[i]);

      // Radius extremes: zero gives zero distance and time, full scale stays below saturation.
      set_radius(24'd0);
      send_route(row_typed(0, 0, 0, LON_MAX, 26'd0, 17'd0));
      send_route(row_typed(0, 0, LAT_MAX, 0, 26'd0, 17'd0));
      set_radius(24'hFFFFFF);
      send_route(row(0, 0, 0, LON_MAX));
      send_route(row(0, 0, 0, 1));
      send_route(row(0, 0, 1, 0));

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_radius(gcdt_pkg::RADIUS_RESET);
            1: set_radius(24'd1);
            2: set_radius(24'($urandom_range(0, 24'hFFFFFF)));
            3: set_radius(24'hFFFFFF);
            default: set_radius(gcdt_pkg::RADIUS_RESET);
         endcase
         for (int n = 0; n < N_RANDOM / 5; n++) begin
            r = row(rand_coord(24, LAT_MAX), rand_coord(25, LON_MAX),
                    rand_coord(24, LAT_MAX), rand_coord(25, LON_MAX));
            // Near-identical and near-antipodal pairs hit the clamps.
            if ($urandom_range(0, 7) == 0) begin
               r.elat = 24'(r.slat + $signed($urandom_range(0, 15)) - 8);
               r.elon = 25'(r.slon + $signed($urandom_range(0, 15)) - 8);
            end else if ($urandom_range(0, 7) == 0) begin
               r.elat = -r.slat;
               r.elon = 25'(r.slon + (r.slon < 0 ? LON_MAX : -LON_MAX));
            end
            send_route(r);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (leg_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) begin
         $display("[great_circle_distance_time] OK");
      end else begin
         $display("[great_circle_distance_time] ERROR");
      end
      $finish;
   end

endmodule
